// ===== hw/rtl/sbfr_pkg.sv =====
// Package for the serial frame receiver.
// Holds frame geometry constants, the configuration struct and register indexes.
// No dependencies.
package sbfr_pkg;

  localparam int unsigned PayloadBytes = 23;
  localparam int unsigned FrameBits    = PayloadBytes * 8;
  localparam int unsigned Channels     = 16;
  localparam int unsigned ChanBits     = 11;
  localparam int unsigned ChanIdxBits  = $clog2(Channels);
  localparam int unsigned PosBits      = 5;
  localparam int unsigned QueueDepth   = 2;

  localparam logic [PosBits-1:0]     PosHunt   = PosBits'(0);
  localparam logic [PosBits-1:0]     PosFooter = PosBits'(PayloadBytes + 1);
  localparam logic [ChanIdxBits-1:0] LastChan  = ChanIdxBits'(Channels - 1);
  localparam logic [7:0]             CountMax  = 8'hFF;
  localparam int unsigned            LostBit     = (PayloadBytes - 1) * 8 + 2;
  localparam int unsigned            FailsafeBit = (PayloadBytes - 1) * 8 + 3;

  typedef enum logic [1:0] {
    CfgMinGood = 2'd0,
    CfgHeader  = 2'd1,
    CfgFooter  = 2'd2
  } cfg_idx_e;

  typedef logic [FrameBits-1:0] frame_t;

  typedef struct packed {
    logic [7:0] min_good;
    logic [7:0] header;
    logic [7:0] footer;
  } cfg_t;

endpackage

// ===== hw/rtl/sbus_frame_receiver_top.sv =====
// Top level of the serial frame receiver: configuration registers, front, queue and back.
// Depends on sbfr_pkg, sbfr_front, sbfr_fifo and sbfr_back.
//
//   Channel   Direction  Width  Contents
//   s_axis    in         8      one received byte per transfer
//   m_axis    out        24     one channel result per transfer, tlast on channel 15
//   cfg       in         2+8    register index and write data, no read-back
//
// The front takes one byte per cycle unless the queue is full; a good frame is queued
// in the cycle its footer is taken. The back gives one channel result per cycle when
// m_axis_tready is high, sixteen per frame, straight from the queue head. Reset clears
// the counters and the queue at once. s_axis_tready falls only while the queue is
// full, so the front keeps taking bytes while a stalled frame waits in the queue.
module sbus_frame_receiver_top #(
  parameter int unsigned QUEUE_DEPTH = sbfr_pkg::QueueDepth
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,  // [7:0] rx_byte
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [3:0] channel_index, [14:4] channel_value, [15] lost_frame, [16] failsafe, rest zero
  output logic [23:0] m_axis_tdata,
  output logic        m_axis_tlast,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [7:0]  cfg_data_i
);
  import sbfr_pkg::*;

  cfg_t                   cfg_q;
  logic                   push, full, pop, empty;
  frame_t                 push_frame, head;
  logic [ChanIdxBits-1:0] chan_idx;
  logic [ChanBits-1:0]    chan_value;
  logic                   lost, failsafe;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.min_good <= 8'd0;
      cfg_q.header   <= 8'd15;
      cfg_q.footer   <= 8'd0;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CfgMinGood: cfg_q.min_good <= cfg_data_i;
        CfgHeader:  cfg_q.header   <= cfg_data_i;
        CfgFooter:  cfg_q.footer   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  sbfr_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .byte_valid_i (s_axis_tvalid),
    .byte_ready_o (s_axis_tready),
    .byte_i       (s_axis_tdata),
    .queue_full_i (full),
    .push_o       (push),
    .push_frame_o (push_frame)
  );

  sbfr_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .push_frame_i (push_frame),
    .full_o       (full),
    .pop_i        (pop),
    .empty_o      (empty),
    .head_o       (head)
  );

  sbfr_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .empty_i      (empty),
    .head_i       (head),
    .pop_o        (pop),
    .res_valid_o  (m_axis_tvalid),
    .res_ready_i  (m_axis_tready),
    .chan_idx_o   (chan_idx),
    .chan_value_o (chan_value),
    .lost_o       (lost),
    .failsafe_o   (failsafe),
    .last_o       (m_axis_tlast)
  );

  assign m_axis_tdata = {7'd0, failsafe, lost, chan_value, chan_idx};

endmodule

// ===== hw/rtl/sbfr_front.sv =====
// Front part of the frame receiver: byte hunting, payload capture and footer check.
// Pushes each frame to be emitted into the frame queue. Depends on sbfr_pkg.
module sbfr_front (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  sbfr_pkg::cfg_t  cfg_i,
  input  logic            byte_valid_i,
  output logic            byte_ready_o,
  input  logic [7:0]      byte_i,
  input  logic            queue_full_i,
  output logic            push_o,
  output sbfr_pkg::frame_t push_frame_o
);
  import sbfr_pkg::*;

  logic [7:0]         prev_q, prev_d;
  logic [PosBits-1:0] pos_q, pos_d;
  logic [7:0]         count_q, count_d;
  logic [7:0]         count_inc;
  frame_t             payload_q, payload_d;
  logic               accept;

  assign byte_ready_o = !queue_full_i;
  assign accept       = byte_valid_i && byte_ready_o;
  assign count_inc    = (count_q != CountMax) ? count_q + 8'd1 : count_q;
  assign push_frame_o = payload_q;

  always_comb begin
    prev_d    = prev_q;
    pos_d     = pos_q;
    count_d   = count_q;
    payload_d = payload_q;
    push_o    = 1'b0;
    if (accept) begin
      prev_d = byte_i;
      if (pos_q == PosHunt) begin
        if (byte_i == cfg_i.header && prev_q == cfg_i.footer) begin
          pos_d = PosBits'(1);
        end
      end else if (pos_q < PosFooter) begin
        payload_d = {byte_i, payload_q[FrameBits-1:8]};
        pos_d     = pos_q + PosBits'(1);
      end else begin
        pos_d = PosHunt;
        if (byte_i == cfg_i.footer) begin
          if (count_inc > cfg_i.min_good) begin
            count_d = count_inc - 8'd1;
            push_o  = 1'b1;
          end else begin
            count_d = count_inc;
          end
        end else begin
          count_d = 8'd0;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_q  <= 8'd0;
      pos_q   <= PosHunt;
      count_q <= 8'd0;
    end else begin
      prev_q  <= prev_d;
      pos_q   <= pos_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    payload_q <= payload_d;
  end

endmodule

// ===== hw/rtl/sbfr_fifo.sv =====
// Short queue of complete frames between the front and back parts.
// Depends on sbfr_pkg for the frame type.
module sbfr_fifo #(
  parameter int unsigned DEPTH = sbfr_pkg::QueueDepth
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  sbfr_pkg::frame_t push_frame_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic             empty_o,
  output sbfr_pkg::frame_t head_o
);
  import sbfr_pkg::*;

  localparam int unsigned PtrBits = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntBits = $clog2(DEPTH + 1);
  localparam logic [PtrBits-1:0] PtrLast = PtrBits'(DEPTH - 1);
  localparam logic [CntBits-1:0] CntFull = CntBits'(DEPTH);

  frame_t             mem_q [DEPTH];
  logic [PtrBits-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [CntBits-1:0] cnt_q, cnt_d;

  assign full_o  = (cnt_q == CntFull);
  assign empty_o = (cnt_q == CntBits'(0));
  assign head_o  = mem_q[rd_q];

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (push_i) begin
      wr_d = (wr_q == PtrLast) ? PtrBits'(0) : wr_q + PtrBits'(1);
    end
    if (pop_i) begin
      rd_d = (rd_q == PtrLast) ? PtrBits'(0) : rd_q + PtrBits'(1);
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + CntBits'(1);
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - CntBits'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= PtrBits'(0);
      rd_q  <= PtrBits'(0);
      cnt_q <= CntBits'(0);
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= push_frame_i;
    end
  end

endmodule

// ===== hw/rtl/sbfr_back.sv =====
// Back part of the frame receiver: unpacks the queued frame into channel results.
// Steps through the channels one transfer at a time. Depends on sbfr_pkg.
module sbfr_back (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             empty_i,
  input  sbfr_pkg::frame_t                 head_i,
  output logic                             pop_o,
  output logic                             res_valid_o,
  input  logic                             res_ready_i,
  output logic [sbfr_pkg::ChanIdxBits-1:0] chan_idx_o,
  output logic [sbfr_pkg::ChanBits-1:0]    chan_value_o,
  output logic                             lost_o,
  output logic                             failsafe_o,
  output logic                             last_o
);
  import sbfr_pkg::*;

  logic [ChanIdxBits-1:0] ch_q, ch_d;
  logic [7:0]             bit_off;
  logic                   accept;

  assign res_valid_o  = !empty_i;
  assign accept       = res_valid_o && res_ready_i;
  assign bit_off      = 8'(ch_q) * 8'(ChanBits);
  assign chan_idx_o   = ch_q;
  assign chan_value_o = head_i[bit_off +: ChanBits];
  assign lost_o       = head_i[LostBit];
  assign failsafe_o   = head_i[FailsafeBit];
  assign last_o       = (ch_q == LastChan);
  assign pop_o        = accept && last_o;

  always_comb begin
    ch_d = ch_q;
    if (accept) begin
      ch_d = ch_q + ChanIdxBits'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ch_q <= '0;
    end else begin
      ch_q <= ch_d;
    end
  end

endmodule

// ===== tb/sv/tb_sbus_frame_receiver_top.sv =====
// Self-checking testbench for sbus_frame_receiver_top: byte transfers in, channel results out.
// Uses its own frame decoder for predictions. Depends on sbfr_pkg and the receiver RTL.
module tb_sbus_frame_receiver_top;
  timeunit 1ns;
  timeprecision 1ps;

  import sbfr_pkg::*;

  localparam int unsigned QuietLimit   = 2000;
  localparam int unsigned SettleCycles = 16;
  localparam int unsigned HoldCycles   = 300;
  localparam logic [1:0]  CfgSpare     = 2'd3;

  typedef struct packed {
    logic [ChanIdxBits-1:0] idx;
    logic [ChanBits-1:0]    value;
    logic                   lost;
    logic                   fs;
    logic                   is_last;
  } chan_result_t;

  typedef struct packed {
    logic [7:0]          fill;
    logic [7:0]          flags;
    logic                good_tail;
    logic                typed;
    logic [ChanBits-1:0] value;
    logic                lost;
    logic                fs;
  } frame_row_t;

  localparam frame_row_t FrameRows [7] = '{
    '{8'h00, 8'h00, 1'b1, 1'b1, 11'd0,    1'b0, 1'b0},
    '{8'hFF, 8'h0C, 1'b1, 1'b1, 11'd2047, 1'b1, 1'b1},
    '{8'hFF, 8'h04, 1'b1, 1'b1, 11'd2047, 1'b1, 1'b0},
    '{8'h00, 8'h08, 1'b1, 1'b1, 11'd0,    1'b0, 1'b1},
    '{8'hA5, 8'hF3, 1'b1, 1'b0, 11'd0,    1'b0, 1'b0},
    '{8'h5A, 8'hFF, 1'b0, 1'b0, 11'd0,    1'b0, 1'b0},
    '{8'h3C, 8'hFB, 1'b1, 1'b0, 11'd0,    1'b0, 1'b0}
  };

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [23:0] m_axis_tdata;
  logic        m_axis_tlast;
  logic        cfg_we_i;
  logic [1:0]  cfg_idx_i;
  logic [7:0]  cfg_data_i;

  // Decoder state and register copies.
  logic [7:0]         min_good_reg = 8'd0;
  logic [7:0]         hdr_reg      = 8'h0F;
  logic [7:0]         ftr_reg      = 8'h00;
  logic [7:0]         rx_prev      = 8'h00;
  logic [PosBits-1:0] rx_pos       = PosHunt;
  frame_t             rx_frame     = '0;
  logic [7:0]         good_frames  = 8'd0;

  chan_result_t chan_expect_q[$];
  int unsigned  fail_count   = 0;
  int unsigned  tx_idle_pct  = 0;
  int unsigned  rx_stall_pct = 0;
  int unsigned  hold_len     = 0;
  logic [7:0]   last_sent    = 8'h00;

  logic                typed_on    = 1'b0;
  logic [ChanBits-1:0] typed_value = '0;
  logic                typed_lost  = 1'b0;
  logic                typed_fs    = 1'b0;

  sbus_frame_receiver_top i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  function automatic void decode_rx_byte(input logic [7:0] b);
    chan_result_t r;
    int k;
    if (rx_pos == PosHunt) begin
      if (b == hdr_reg && rx_prev == ftr_reg) rx_pos = PosBits'(1);
    end else if (rx_pos <= PayloadBytes) begin
      rx_frame[(rx_pos - 1) * 8 +: 8] = b;
      rx_pos = rx_pos + PosBits'(1);
    end else begin
      rx_pos = PosHunt;
      if (b == ftr_reg) begin
        if (good_frames != CountMax) good_frames = good_frames + 8'd1;
        if (good_frames > min_good_reg) begin
          good_frames = good_frames - 8'd1;
          for (k = 0; k < Channels; k++) begin
            r.idx     = ChanIdxBits'(k);
            r.value   = rx_frame[k * ChanBits +: ChanBits];
            r.lost    = rx_frame[LostBit];
            r.fs      = rx_frame[FailsafeBit];
            r.is_last = (k == Channels - 1);
            if (typed_on) begin
              r.value = typed_value;
              r.lost  = typed_lost;
              r.fs    = typed_fs;
            end
            chan_expect_q.push_back(r);
          end
        end
      end else begin
        good_frames = 8'd0;
      end
    end
    rx_prev = b;
  endfunction

  function automatic void check_field(input string name, input logic [10:0] exp_v, got_v);
    if (got_v !== exp_v) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, exp_v, got_v);
      fail_count++;
    end
  endfunction

  always @(posedge clk_i) begin : monitor
    chan_result_t want;
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (chan_expect_q.size() == 0) begin
          $display("%0t: unexpected channel result, expected none, got index %0d value %0d",
                   $time, m_axis_tdata[3:0], m_axis_tdata[14:4]);
          fail_count++;
        end else begin
          want = chan_expect_q.pop_front();
          check_field("channel_index", 11'(want.idx), 11'(m_axis_tdata[3:0]));
          check_field("channel_value", want.value, m_axis_tdata[14:4]);
          check_field("lost_frame", 11'(want.lost), 11'(m_axis_tdata[15]));
          check_field("failsafe", 11'(want.fs), 11'(m_axis_tdata[16]));
          check_field("last_channel", 11'(want.is_last), 11'(m_axis_tlast));
        end
      end
      if (s_axis_tvalid && s_axis_tready) decode_rx_byte(s_axis_tdata);
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CfgMinGood: min_good_reg = cfg_data_i;
          CfgHeader:  hdr_reg      = cfg_data_i;
          CfgFooter:  ftr_reg      = cfg_data_i;
          default: ;
        endcase
      end
    end
  end

  initial begin : result_sink
    m_axis_tready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_len != 0) begin
        m_axis_tready <= 1'b0;
        repeat (hold_len) @(posedge clk_i);
        hold_len = 0;
      end else begin
        m_axis_tready <= ($urandom_range(99) >= rx_stall_pct);
      end
    end
  end

  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < QuietLimit) begin
      @(posedge clk_i);
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) quiet = 0;
      else quiet++;
    end
    $display("== FAIL ==");
    $finish;
  end

  task automatic send_byte(input logic [7:0] b);
    while ($urandom_range(99) < tx_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= 8'($urandom);
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    last_sent = b;
  endtask

  task automatic send_frame(input frame_t body, input bit good_tail);
    int i;
    if (last_sent != ftr_reg) send_byte(ftr_reg);
    send_byte(hdr_reg);
    for (i = 0; i < PayloadBytes; i++) send_byte(body[i * 8 +: 8]);
    send_byte(good_tail ? ftr_reg : ftr_reg ^ 8'($urandom_range(1, 255)));
  endtask

  task automatic await_idle();
    s_axis_tvalid <= 1'b0;
    while (chan_expect_q.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_config(input logic [7:0] min_v, hdr_v, ftr_v);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= CfgMinGood;
    cfg_data_i <= min_v;
    @(posedge clk_i);
    cfg_idx_i  <= CfgHeader;
    cfg_data_i <= hdr_v;
    @(posedge clk_i);
    cfg_idx_i  <= CfgFooter;
    cfg_data_i <= ftr_v;
    @(posedge clk_i);
    cfg_idx_i  <= CfgSpare;
    cfg_data_i <= 8'($urandom);
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
  endtask

  task automatic run_phase(input logic [7:0] min_v, hdr_v, ftr_v,
                           input int unsigned tx_pct, rx_pct, n_frames,
                           input bit clean, input int unsigned hold);
    frame_t body;
    int unsigned f;
    int i;
    await_idle();
    write_config(min_v, hdr_v, ftr_v);
    tx_idle_pct  = tx_pct;
    rx_stall_pct = rx_pct;
    hold_len     = hold;
    for (f = 0; f < n_frames; f++) begin
      if (!clean && $urandom_range(3) == 0) begin
        repeat ($urandom_range(1, 3)) send_byte(8'($urandom));
      end
      for (i = 0; i < PayloadBytes; i++) body[i * 8 +: 8] = 8'($urandom);
      send_frame(body, clean || $urandom_range(9) != 0);
    end
  endtask

  initial begin : stimulus
    frame_t body;
    int r;
    int i;
    rst_ni        <= 1'b0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= 8'h00;
    cfg_we_i      <= 1'b0;
    cfg_idx_i     <= CfgMinGood;
    cfg_data_i    <= 8'h00;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset register values: every good frame is emitted.
    for (r = 0; r < 7; r++) begin
      typed_on    <= FrameRows[r].typed;
      typed_value <= FrameRows[r].value;
      typed_lost  <= FrameRows[r].lost;
      typed_fs    <= FrameRows[r].fs;
      for (i = 0; i < PayloadBytes - 1; i++) body[i * 8 +: 8] = FrameRows[r].fill;
      body[(PayloadBytes - 1) * 8 +: 8] = FrameRows[r].flags;
      send_frame(body, FrameRows[r].good_tail);
    end
    await_idle();
    typed_on <= 1'b0;

    run_phase(8'd0, 8'h7E, 8'h00, 0, 0, 1, 1'b0, 0);
    run_phase(8'd2, 8'hFF, 8'hFF, 65, 0, 3, 1'b0, 0);
    run_phase(8'd1, 8'h00, 8'hA5, 0, 65, 2, 1'b0, 0);
    run_phase(8'($urandom_range(0, 1)), 8'($urandom), 8'($urandom), 24, 24, 2, 1'b0, 0);
    run_phase(8'd0, 8'h0F, 8'h00, 0, 0, 3, 1'b1, HoldCycles);
    await_idle();
    // With the highest minimum no good frame is let out.
    run_phase(8'd255, 8'h00, 8'hFF, 0, 0, 1, 1'b1, 0);
    await_idle();

    if (fail_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
